### hdl/metronome_click_mixer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the metronome click mixer
// Implication and next-cycle checks; they compile to nothing with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef METRONOME_CLICK_MIXER_TOP_ASSERT_SVH
`define METRONOME_CLICK_MIXER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MCM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mcm assertion failed");

// next-cycle implication
`define MCM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mcm assertion failed");

`else

`define MCM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MCM_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

### hdl/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared constants and types for the metronome click mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_pkg;

    // register field widths
    localparam int PERIOD_W = 19;
    localparam int LEN_W    = 13;
    localparam int STEP_W   = 15;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 8'd3;

    // register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 19'd24000;
    localparam logic [LEN_W-1:0]    LEN_RST    = 13'd1680;
    localparam logic [STEP_W-1:0]   STEP_RST   = 15'd2321;

    // sine polynomial and click gain (0.16 = 10486 / 65536)
    localparam logic [15:0] SIN_A      = 16'd51472;
    localparam logic [15:0] SIN_B      = 16'd21024;
    localparam logic [15:0] SIN_C      = 16'd2320;
    localparam logic [15:0] CLICK_GAIN = 16'd10486;
    localparam logic [14:0] SIN_MAX    = 15'd32767;

    // shared multiplier
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // iterative divider, DIV_RADIX_BITS quotient bits per cycle
    localparam int DIV_W          = PROD_W;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_CYCLES     = DIV_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES + 1);

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### hdl/mcm_mul.sv
// ----------------------------------------------------------------------------
// mcm_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_mul (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [mcm_pkg::MUL_A_W-1:0]   op_a,
    input  wire logic [mcm_pkg::MUL_B_W-1:0]   op_b,
    output logic      [mcm_pkg::PROD_W-1:0]    prod
);

    logic [mcm_pkg::PROD_W-1:0] prod_reg;

    // product register, loaded only when a step uses the unit
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= mcm_pkg::PROD_W'(op_a) * mcm_pkg::PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### hdl/mcm_div.sv
// ----------------------------------------------------------------------------
// mcm_div
// Iterative restoring divider, DIV_RADIX_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [mcm_pkg::DIV_W-1:0]     dividend,
    input  wire logic [mcm_pkg::LEN_W-1:0]     divisor,
    output logic      [mcm_pkg::DIV_W-1:0]     quotient,
    output mcm_pkg::div_stat_t                 stat
);

    logic [mcm_pkg::DIV_W-1:0]     dq_reg;
    logic [mcm_pkg::DIV_W-1:0]     dq_next;
    logic [mcm_pkg::LEN_W-1:0]     rem_reg;
    logic [mcm_pkg::LEN_W-1:0]     rem_next;
    logic [mcm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    // DIV_RADIX_BITS shift-subtract steps; dividend shifts out, quotient in
    always_comb begin
        logic [mcm_pkg::LEN_W:0]   trial;
        logic [mcm_pkg::LEN_W-1:0] r;
        logic [mcm_pkg::DIV_W-1:0] d;
        r = rem_reg;
        d = dq_reg;
        for (int i = 0; i < mcm_pkg::DIV_RADIX_BITS; i++) begin
            trial = {r, d[mcm_pkg::DIV_W-1]};
            d     = {d[mcm_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                r    = mcm_pkg::LEN_W'(trial - {1'b0, divisor});
                d[0] = 1'b1;
            end else begin
                r = trial[mcm_pkg::LEN_W-1:0];
            end
        end
        rem_next = r;
        dq_next  = d;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == mcm_pkg::DIV_CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= mcm_pkg::DIV_CNT_W'(mcm_pkg::DIV_CYCLES);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - mcm_pkg::DIV_CNT_W'(1);
                if (cnt_reg == mcm_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = dq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### hdl/metronome_click_mixer_top.sv
// Sequence: while a click sounds, an accepted sample makes six passes through
//   the shared multiplier, then the divider (4 quotient bits per step); with
//   no click or the block disabled it goes straight to the output register.
// Flow: one word at a time; the next sample is accepted while the previous
//   word waits at the output, and a second finished word stalls input.
// Reset: synchronous active-low aresetn clears state and loads register defaults.
`default_nettype none
`include "metronome_click_mixer_top_assert.svh"

// ----------------------------------------------------------------------------
// metronome_click_mixer_top
// Beat counter, decaying sine click and saturating mix into the sample stream.
// ----------------------------------------------------------------------------
module metronome_click_mixer_top #(
    parameter int PHASE_BITS  = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mcm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [mcm_pkg::CFG_DATA_W-1:0]        cfg_data,
    // samples in
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]         s_in_sample,
    // results out
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [SAMPLE_BITS-1:0]              m_out_sample,
    output logic signed [SAMPLE_BITS-1:0]              m_click_sample,
    output logic                                       m_beat_start
);

    localparam int SUM_W     = (PHASE_BITS > mcm_pkg::STEP_W) ? PHASE_BITS : mcm_pkg::STEP_W;
    localparam int DIV_SHIFT = 32 - SAMPLE_BITS;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_SQ       = 10'b0000000010,
        ST_CZ       = 10'b0000000100,
        ST_TZ       = 10'b0000001000,
        ST_TU       = 10'b0000010000,
        ST_SR       = 10'b0000100000,
        ST_GAIN     = 10'b0001000000,
        ST_DIV_GO   = 10'b0010000000,
        ST_DIV_WAIT = 10'b0100000000,
        ST_FINISH   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration registers
    logic                         enable_reg;
    logic [mcm_pkg::PERIOD_W-1:0] period_reg;
    logic [mcm_pkg::LEN_W-1:0]    len_reg;
    logic [mcm_pkg::STEP_W-1:0]   step_reg;

    // running state
    logic [mcm_pkg::PERIOD_W-1:0] countdown_reg;
    logic [mcm_pkg::LEN_W-1:0]    remaining_reg;
    logic [PHASE_BITS-1:0]        phase_reg;

    // per-word working registers
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [mcm_pkg::LEN_W-1:0]     cur_rem_reg;
    logic [15:0]                   idx_reg;
    logic                          start_reg;
    logic                          active_reg;
    logic [15:0]                   z_reg;

    // output register
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_out_reg;
    logic signed [SAMPLE_BITS-1:0] m_click_reg;
    logic                          m_beat_reg;

    logic                         accept;
    logic                         out_load;
    logic [mcm_pkg::PERIOD_W-1:0] period_eff;
    logic [mcm_pkg::LEN_W-1:0]    len_eff;
    logic                         start_now;
    logic [mcm_pkg::LEN_W-1:0]    rem_eff;
    logic [PHASE_BITS-1:0]        phase_eff;
    logic                         active_now;
    logic [SUM_W-1:0]             phase_sum;
    logic [15:0]                  idx_now;

    logic [14:0]                  x_mir;
    logic [15:0]                  u_val;
    logic [15:0]                  prod_q15;
    logic [14:0]                  s_clamp;

    logic                         mul_en;
    logic [mcm_pkg::MUL_A_W-1:0]  mul_a;
    logic [mcm_pkg::MUL_B_W-1:0]  mul_b;
    logic [mcm_pkg::PROD_W-1:0]   prod;

    logic                         div_start;
    logic [mcm_pkg::DIV_W-1:0]    quotient;
    mcm_pkg::div_stat_t           div_stat;

    logic signed [SAMPLE_BITS-1:0] click_val;
    logic signed [SAMPLE_BITS:0]   mix_sum;
    logic signed [SAMPLE_BITS-1:0] mix_sat;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // beat and click bookkeeping seen by the incoming word
    assign period_eff = (period_reg == '0) ? mcm_pkg::PERIOD_W'(1) : period_reg;
    assign len_eff    = (len_reg == '0) ? mcm_pkg::LEN_W'(1) : len_reg;
    assign start_now  = enable_reg && (countdown_reg == '0);
    assign rem_eff    = start_now ? len_eff : remaining_reg;
    assign phase_eff  = start_now ? '0 : phase_reg;
    assign active_now = enable_reg && (rem_eff != '0);
    assign phase_sum  = SUM_W'(phase_eff) + SUM_W'(step_reg);

    // top 16 phase bits (zero-padded when narrower) address the sine
    generate
        if (PHASE_BITS >= 16) begin : g_idx_wide
            assign idx_now = phase_eff[PHASE_BITS-1 -: 16];
        end else begin : g_idx_narrow
            assign idx_now = {phase_eff, {(16 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    // quarter-wave fold
    assign x_mir    = idx_reg[14] ? (15'd16384 - {1'b0, idx_reg[13:0]})
                                  : {1'b0, idx_reg[13:0]};
    assign u_val    = {x_mir, 1'b0};
    assign prod_q15 = prod[30:15];
    assign s_clamp  = (prod_q15 > {1'b0, mcm_pkg::SIN_MAX}) ? mcm_pkg::SIN_MAX
                                                           : prod_q15[14:0];

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = active_now ? ST_SQ : ST_FINISH;
                end
            end
            ST_SQ:       state_next = ST_CZ;
            ST_CZ:       state_next = ST_TZ;
            ST_TZ:       state_next = ST_TU;
            ST_TU:       state_next = ST_SR;
            ST_SR:       state_next = ST_GAIN;
            ST_GAIN:     state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_SQ: begin
                mul_a = mcm_pkg::MUL_A_W'(u_val);
                mul_b = u_val;
            end
            ST_CZ: begin
                mul_a = mcm_pkg::MUL_A_W'(mcm_pkg::SIN_C);
                mul_b = prod_q15;
            end
            ST_TZ: begin
                mul_a = mcm_pkg::MUL_A_W'(mcm_pkg::SIN_B - prod_q15);
                mul_b = z_reg;
            end
            ST_TU: begin
                mul_a = mcm_pkg::MUL_A_W'(mcm_pkg::SIN_A - prod_q15);
                mul_b = u_val;
            end
            ST_SR: begin
                mul_a = mcm_pkg::MUL_A_W'(s_clamp);
                mul_b = mcm_pkg::MUL_B_W'(cur_rem_reg);
            end
            ST_GAIN: begin
                mul_a = prod[mcm_pkg::MUL_A_W-1:0];
                mul_b = mcm_pkg::CLICK_GAIN;
            end
            default: mul_en = 1'b0;
        endcase
    end

    mcm_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // magnitude / (len << (32 - SAMPLE_BITS)) == (magnitude >> shift) / len
    assign div_start = (state_reg == ST_DIV_GO);

    mcm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod >> DIV_SHIFT),
        .divisor  (len_eff),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // signed, saturated click from the quotient
    always_comb begin
        click_val = '0;
        if (active_reg) begin
            if (quotient[mcm_pkg::DIV_W-1:SAMPLE_BITS-1] == '0) begin
                click_val = idx_reg[15] ? -$signed(quotient[SAMPLE_BITS-1:0])
                                        :  $signed(quotient[SAMPLE_BITS-1:0]);
            end else begin
                click_val = idx_reg[15] ? $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})
                                        : $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
            end
        end
    end

    // saturating mix
    assign mix_sum = {sample_reg[SAMPLE_BITS-1], sample_reg}
                   + {click_val[SAMPLE_BITS-1], click_val};
    assign mix_sat = (mix_sum[SAMPLE_BITS] != mix_sum[SAMPLE_BITS-1])
                   ? (mix_sum[SAMPLE_BITS] ? $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})
                                           : $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}))
                   : mix_sum[SAMPLE_BITS-1:0];

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            period_reg    <= mcm_pkg::PERIOD_RST;
            len_reg       <= mcm_pkg::LEN_RST;
            step_reg      <= mcm_pkg::STEP_RST;
            countdown_reg <= '0;
            remaining_reg <= '0;
            phase_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            // advance beat, envelope and phase as the word comes in
            if (accept && enable_reg) begin
                countdown_reg <= (start_now ? period_eff : countdown_reg)
                               - mcm_pkg::PERIOD_W'(1);
                if (active_now) begin
                    phase_reg     <= phase_sum[PHASE_BITS-1:0];
                    remaining_reg <= rem_eff - mcm_pkg::LEN_W'(1);
                end
            end

            // register writes; a new tempo restarts the beat
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mcm_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
                    mcm_pkg::CFG_PERIOD: begin
                        period_reg    <= cfg_data[mcm_pkg::PERIOD_W-1:0];
                        countdown_reg <= '0;
                    end
                    mcm_pkg::CFG_LENGTH: len_reg  <= cfg_data[mcm_pkg::LEN_W-1:0];
                    mcm_pkg::CFG_STEP:   step_reg <= cfg_data[mcm_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end

            // output word handshake
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working and output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg  <= s_in_sample;
            start_reg   <= start_now;
            active_reg  <= active_now;
            cur_rem_reg <= rem_eff;
            idx_reg     <= idx_now;
        end
        if (state_reg == ST_CZ) begin
            z_reg <= prod_q15;
        end
        if (out_load) begin
            m_out_reg   <= mix_sat;
            m_click_reg <= click_val;
            m_beat_reg  <= start_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_sample   = m_out_reg;
    assign m_click_sample = m_click_reg;
    assign m_beat_start   = m_beat_reg;

    // checks
    `MCM_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != ST_IDLE)
    `MCM_ASSERT_IMP(a_div_done_in_wait, aclk, aresetn, div_stat.done, state_reg == ST_DIV_WAIT)
    `MCM_ASSERT_IMP(a_div_busy_in_wait, aclk, aresetn, div_stat.busy, state_reg == ST_DIV_WAIT)
    `MCM_ASSERT_IMP(a_out_from_finish, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_FINISH)

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the metronome click mixer: a directed table of samples
// and register writes, then randomized phases under several idle and stall
// patterns; each result word must match a fixed or predicted word bit-exactly.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int SW = 24;
    localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SW-1:0] S_MIN = 24'sh800000;

    // indexes that map to no register
    localparam logic [mcm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 8'd4;
    localparam logic [mcm_pkg::CFG_IDX_W-1:0] CFG_LAST  = 8'hFF;

    localparam int SETTLE      = 40;      // cycles past the last word before a write
    localparam int TAIL        = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [SW-1:0] out_sample;
        logic signed [SW-1:0] click_sample;
        logic                 beat_start;
    } mix_word_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [mcm_pkg::CFG_IDX_W-1:0]   idx;
        logic [mcm_pkg::CFG_DATA_W-1:0]  data;
        logic signed [SW-1:0]            smp;
        logic                            fixed;
        mix_word_t                       want;
    } row_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // DUT ports
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [mcm_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [mcm_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    logic signed [SW-1:0]              s_in_sample = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [SW-1:0]              m_out_sample;
    logic signed [SW-1:0]              m_click_sample;
    logic                              m_beat_start;

    metronome_click_mixer_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_sample    (s_in_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_sample   (m_out_sample),
        .m_click_sample (m_click_sample),
        .m_beat_start   (m_beat_start)
    );

    // ------------------------------------------------------------------------
    // Predictor: shadow registers and click state
    // ------------------------------------------------------------------------
    logic                        cf_enable = 1'b0;
    logic [mcm_pkg::PERIOD_W-1:0] cf_period = mcm_pkg::PERIOD_RST;
    logic [mcm_pkg::LEN_W-1:0]    cf_length = mcm_pkg::LEN_RST;
    logic [mcm_pkg::STEP_W-1:0]   cf_step   = mcm_pkg::STEP_RST;
    logic [mcm_pkg::PERIOD_W-1:0] st_count  = '0;
    logic [mcm_pkg::LEN_W-1:0]    st_left   = '0;
    logic [15:0]                  st_phase  = '0;

    mix_word_t mix_q[$];    // expected result words, oldest first
    int        err_cnt   = 0;
    int        cycle_cnt = 0;

    // sender and receiver pacing
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    bit   drain_first  = 1'b0;
    int   hold_req_cnt = 0;
    int   hold_ack_cnt = 0;
    int   hold_left    = 0;

    function automatic longint clamp_sample(input longint v);
        if (v > longint'(S_MAX)) return longint'(S_MAX);
        if (v < longint'(S_MIN)) return longint'(S_MIN);
        return v;
    endfunction

    // quarter-wave polynomial sine, Q1.15
    function automatic int tone_sine(input logic [15:0] ph);
        logic [1:0]       quad;
        longint unsigned  x, u, z, t, s;
        quad = ph[15:14];
        x = ph[13:0];
        if (quad[0]) x = 64'd16384 - x;
        u = x << 1;
        z = (u * u) >> 15;
        t = (64'(mcm_pkg::SIN_C) * z) >> 15;
        t = 64'(mcm_pkg::SIN_B) - t;
        t = (t * z) >> 15;
        t = 64'(mcm_pkg::SIN_A) - t;
        s = (t * u) >> 15;
        if (s > 64'(mcm_pkg::SIN_MAX)) s = 64'(mcm_pkg::SIN_MAX);
        return quad[1] ? -int'(s) : int'(s);
    endfunction

    function automatic void apply_register(input logic [mcm_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [mcm_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            mcm_pkg::CFG_ENABLE: cf_enable = data[0];
            mcm_pkg::CFG_PERIOD: begin
                cf_period = data[mcm_pkg::PERIOD_W-1:0];
                st_count  = '0;
            end
            mcm_pkg::CFG_LENGTH: cf_length = data[mcm_pkg::LEN_W-1:0];
            mcm_pkg::CFG_STEP:   cf_step   = data[mcm_pkg::STEP_W-1:0];
            default: ;
        endcase
    endfunction

    // one sample tick: advance the shadow state, return the mixed word
    function automatic mix_word_t predict_mix(input logic signed [SW-1:0] smp);
        mix_word_t                    w;
        logic [mcm_pkg::PERIOD_W-1:0] period;
        logic [mcm_pkg::LEN_W-1:0]    len;
        int                           sv;
        longint                       mag, click, total;
        click = 0;
        w.beat_start = 1'b0;
        if (cf_enable) begin
            period = (cf_period == 0) ? 19'd1 : cf_period;
            len    = (cf_length == 0) ? 13'd1 : cf_length;
            if (st_count == 0) begin
                st_count = period;
                st_left  = len;
                st_phase = '0;
                w.beat_start = 1'b1;
            end
            if (st_left != 0) begin
                sv  = tone_sine(st_phase);
                mag = longint'(sv < 0 ? -sv : sv) * longint'(st_left)
                      * longint'(mcm_pkg::CLICK_GAIN);
                mag = mag / (longint'(len) << (32 - SW));
                click = clamp_sample(sv < 0 ? -mag : mag);
                st_phase = st_phase + 16'(cf_step);
                st_left  = st_left - 1'b1;
            end
            st_count = st_count - 1'b1;
        end
        total = clamp_sample(longint'(smp) + click);
        w.out_sample   = total[SW-1:0];
        w.click_sample = click[SW-1:0];
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    function automatic row_t row_write(input logic [mcm_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [mcm_pkg::CFG_DATA_W-1:0] data);
        row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic row_t row_mix(input logic signed [SW-1:0] smp);
        row_t r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.smp  = smp;
        return r;
    endfunction

    function automatic row_t row_fixed(input logic signed [SW-1:0] smp,
                                       input logic signed [SW-1:0] out_s,
                                       input logic signed [SW-1:0] click_s,
                                       input logic beat);
        row_t r;
        r = row_mix(smp);
        r.fixed = 1'b1;
        r.want  = '{out_s, click_s, beat};
        return r;
    endfunction

    localparam int N_ROWS = 27;
    localparam row_t DIR_ROWS [0:N_ROWS-1] = '{
        // disabled after reset: pass-through at the extremes
        row_fixed(S_MAX, S_MAX, 0, 1'b0),
        row_fixed(S_MIN, S_MIN, 0, 1'b0),
        row_fixed(0, 0, 0, 1'b0),
        // first enabled tick starts a click at phase zero
        row_write(mcm_pkg::CFG_ENABLE, 19'd1),
        row_fixed(0, 0, 0, 1'b1),
        row_mix(S_MAX),
        row_mix(S_MIN),
        // length cut to zero mid-click, upper data bits dropped
        row_write(mcm_pkg::CFG_LENGTH, 19'h7E000),
        row_mix(0),
        row_mix(100),
        row_write(mcm_pkg::CFG_STEP, 19'h7FFFF),
        row_mix(-1),
        row_mix(1),
        // zero beat period restarts every tick
        row_write(mcm_pkg::CFG_PERIOD, 19'd0),
        row_fixed(5, 5, 0, 1'b1),
        row_fixed(-7, -7, 0, 1'b1),
        // quarter-turn step hits the sine peak clamp
        row_write(mcm_pkg::CFG_PERIOD, 19'd3),
        row_write(mcm_pkg::CFG_LENGTH, 19'd8191),
        row_write(mcm_pkg::CFG_STEP, 19'd16384),
        row_fixed(0, 0, 0, 1'b1),
        row_mix(0),
        row_mix(S_MIN),
        // writes to unmapped indexes change nothing
        row_write(CFG_SPARE, 19'h5A5A5),
        row_write(CFG_LAST, 19'h7FFFF),
        row_mix(S_MAX),
        row_write(mcm_pkg::CFG_ENABLE, 19'd0),
        row_fixed(1234, 1234, 0, 1'b0)
    };

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [mcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mcm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering samples and let the block run dry
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (mix_q.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_sample(input logic signed [SW-1:0] smp, input bit use_fixed,
                               input mix_word_t fixed_w);
        mix_word_t w;
        if (drain_first) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (mix_q.size() != 0);
            drain_first = 1'b0;
        end else if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid     <= 1'b1;
        s_in_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        w = predict_mix(smp);
        mix_q.push_back(use_fixed ? fixed_w : w);
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0:       return S_MAX;
            1:       return S_MIN;
            default: return SW'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: ready pacing and word check
    // ------------------------------------------------------------------------
    task automatic check_word();
        mix_word_t want;
        if (mix_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("[%0t] result word with nothing expected: out=%0d click=%0d beat=%0b",
                         $realtime, m_out_sample, m_click_sample, m_beat_start);
            return;
        end
        want = mix_q.pop_front();
        if (m_out_sample !== want.out_sample || m_click_sample !== want.click_sample ||
            m_beat_start !== want.beat_start) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("[%0t] mismatch: out %0d/%0d click %0d/%0d beat %0b/%0b (exp/got)",
                         $realtime, want.out_sample, m_out_sample, want.click_sample,
                         m_click_sample, want.beat_start, m_beat_start);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_word();
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, mix_q.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [mcm_pkg::CFG_DATA_W-1:0] d;
        int                             mode;
        bit                             en;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        for (int i = 0; i < N_ROWS; i++) begin
            if (DIR_ROWS[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            end else begin
                send_sample(DIR_ROWS[i].smp, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
            end
        end

        // random phases, each with its own settings and pacing
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            mode = p % 4;
            tx_idle_pct  = (mode == 1) ? 56 : (mode == 3) ? 38 : 0;
            rx_stall_pct <= (mode == 2) ? 56 : (mode == 3) ? 38 : 0;

            en = (p != 3) && ($urandom_range(0, 7) != 0 || p < 2);
            d = 19'($urandom);
            d[0] = en;
            write_reg(mcm_pkg::CFG_ENABLE, d);

            if (p == 0) begin
                write_reg(mcm_pkg::CFG_PERIOD, 19'd0);
                write_reg(mcm_pkg::CFG_LENGTH, 19'd8191);
                write_reg(mcm_pkg::CFG_STEP, 19'h7FFFF);
            end else if (p == 1) begin
                write_reg(mcm_pkg::CFG_PERIOD, 19'd524287);
                write_reg(mcm_pkg::CFG_LENGTH, 19'h7FFFF);
                write_reg(mcm_pkg::CFG_STEP, 19'd1);
            end else begin
                // period is rewritten only sometimes so clicks can span phases
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 9))
                        0:       d = 19'd0;
                        1:       d = 19'd524287;
                        2:       d = 19'd1;
                        default: d = 19'($urandom_range(2, 200));
                    endcase
                    write_reg(mcm_pkg::CFG_PERIOD, d);
                end
                case ($urandom_range(0, 9))
                    0:       d = 19'd0;
                    1:       d = 19'd8191;
                    2:       d = 19'($urandom);
                    default: d = 19'($urandom_range(1, 150));
                endcase
                write_reg(mcm_pkg::CFG_LENGTH, d);
                case ($urandom_range(0, 7))
                    0:       d = 19'd0;
                    1:       d = 19'd32767;
                    default: d = 19'($urandom);
                endcase
                write_reg(mcm_pkg::CFG_STEP, d);
            end
            write_reg(8'($urandom_range(CFG_SPARE, CFG_LAST)), 19'($urandom));

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // long receiver hold so the block backs up into its input
                if (p == 5 && k == 10) hold_req_cnt <= hold_req_cnt + 1;
                // sender pause until every word is back
                if (p == 6 && k == 30) drain_first = 1'b1;
                send_sample(rand_sample(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (mix_q.size() != 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);

        if (err_cnt == 0 && mix_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
